### hdl/csat_pkg.sv
// Shared types and constants of the class-count summed-area table.
// No dependencies; imported by the top level and the checker.
package csat_pkg;

  // Field widths
  localparam int REG_W       = 11;
  localparam int CELL_W      = 8;
  localparam int COUNT_W     = 21;
  localparam int NUM_CLASSES = 3;
  localparam int TOTALS_W    = NUM_CLASSES * COUNT_W;

  // Size defaults
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // Reset value of both size registers
  localparam logic [REG_W-1:0] REG_RESET = 11'd1024;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH  = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } cfg_reg_t;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

### hdl/csat_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module csat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/class_count_summed_area_table.sv
// Top level of the class-count summed-area table.
// Depends on csat_pkg and csat_ram (line buffer of the previous row's totals).
//
// Cells stream in raster order, one item per clock while results are taken; a result is
// offered once its item leaves the read stage (the line buffer is read at the accepting edge,
// the add and write-back happen as the read stage advances, also loading the output register).
// The rate is set by the line buffer: one read and one write per cycle, at the column of
// the cell. When a row is one cell wide, the next cell reads the entry being written in
// the same cycle, and the written totals are forwarded in place of the buffer's data.
// The output register lets a new item enter while a result waits to be taken; the input
// stalls only when both the output register and the read stage are full. The line buffer
// needs no clearing: the first row of a frame takes the totals above as zero.
// Size registers take effect at once and must change only between items.
module class_count_summed_area_table
  import csat_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  // Input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CELL_W-1:0]    in_cell_value,
  // Result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COUNT_W-1:0]   out_class0_count,
  output logic [COUNT_W-1:0]   out_class1_count,
  output logic [COUNT_W-1:0]   out_class2_count,
  output logic [CELL_W-1:0]    out_cell_color,
  output logic                 out_frame_end
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CSZ_W  = ($clog2(MAX_COLS + 1) > REG_W) ? $clog2(MAX_COLS + 1) : REG_W;
  localparam int RSZ_W  = ($clog2(MAX_ROWS + 1) > REG_W) ? $clog2(MAX_ROWS + 1) : REG_W;

  // Size registers
  logic [REG_W-1:0] row_width_r, frame_rows_r;

  // Position and row running sums
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  count_t           run_r   [NUM_CLASSES];
  count_t           run_nxt [NUM_CLASSES];
  count_t           run_sum [NUM_CLASSES];

  // Read stage
  logic              s1_valid_r, s1_valid_nxt;
  count_t            s1_run_r [NUM_CLASSES];
  logic              s1_first_row_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_end_r;
  logic              fwd_r;
  logic [TOTALS_W-1:0] fwd_data_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  count_t            out_tot_r [NUM_CLASSES];
  logic [CELL_W-1:0] out_cell_r;
  logic              out_end_r;

  logic                in_acc, advance, wr_en;
  logic [CSZ_W-1:0]    rw_ext, cols;
  logic [RSZ_W-1:0]    fr_ext, rows;
  logic                last_col, last_row;
  logic [TOTALS_W-1:0] ram_rdata, above, wr_data;
  count_t              total [NUM_CLASSES];

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = s1_valid_r && advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= REG_RESET;
      frame_rows_r <= REG_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH:  row_width_r  <= cfg_data;
        REG_FRAME_ROWS: frame_rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX
  always_comb begin
    rw_ext = CSZ_W'(row_width_r);
    fr_ext = RSZ_W'(frame_rows_r);
    if (rw_ext == '0)                  cols = CSZ_W'(1);
    else if (rw_ext > CSZ_W'(MAX_COLS)) cols = CSZ_W'(MAX_COLS);
    else                               cols = rw_ext;
    if (fr_ext == '0)                  rows = RSZ_W'(1);
    else if (fr_ext > RSZ_W'(MAX_ROWS)) rows = RSZ_W'(MAX_ROWS);
    else                               rows = fr_ext;
    last_col = (CSZ_W'(col_r) + CSZ_W'(1)) >= cols;
    last_row = (RSZ_W'(row_r) + RSZ_W'(1)) >= rows;
  end

  // Running sums and next position
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      run_sum[k] = run_r[k] + ((in_cell_value == CELL_W'(k)) ? count_t'(1) : count_t'(0));
      run_nxt[k] = last_col ? '0 : run_sum[k];
    end
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) run_r[k] <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int k = 0; k < NUM_CLASSES; k++) run_r[k] <= run_nxt[k];
    end
  end

  // Read stage control
  always_comb begin
    if (in_acc)       s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    else              s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Read stage payload; forward when the same entry is written at the read edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < NUM_CLASSES; k++) s1_run_r[k] <= run_sum[k];
      s1_first_row_r <= (row_r == '0);
      s1_cell_r      <= in_cell_value;
      s1_col_r       <= col_r;
      s1_end_r       <= last_col && last_row;
      fwd_r          <= wr_en && (s1_col_r == col_r);
      fwd_data_r     <= wr_data;
    end
  end

  // Line buffer of the previous row's totals
  csat_ram #(
    .WIDTH (TOTALS_W),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Totals: above plus the row's running sum
  always_comb begin
    if (s1_first_row_r) above = '0;
    else if (fwd_r)     above = fwd_data_r;
    else                above = ram_rdata;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      total[k] = above[k*COUNT_W +: COUNT_W] + s1_run_r[k];
      wr_data[k*COUNT_W +: COUNT_W] = total[k];
    end
  end

  // Output register
  always_comb begin
    if (wr_en)         out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < NUM_CLASSES; k++) out_tot_r[k] <= total[k];
      out_cell_r <= s1_cell_r;
      out_end_r  <= s1_end_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_class0_count = out_tot_r[0];
  assign out_class1_count = out_tot_r[1];
  assign out_class2_count = out_tot_r[2];
  assign out_cell_color   = out_cell_r;
  assign out_frame_end    = out_end_r;

endmodule

### hdl/csat_checker.sv
// Port-level checks of the class-count summed-area table, bound to the top level.
// Depends on csat_pkg and class_count_summed_area_table.
module csat_checker
  import csat_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_class0_count,
  input logic [COUNT_W-1:0] out_class1_count,
  input logic [COUNT_W-1:0] out_class2_count,
  input logic [CELL_W-1:0]  out_cell_color,
  input logic               out_frame_end
);

  // Items inside the block: two stages at most
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc)      pend_nxt = pend_r + 2'd1;
    else if (!in_acc && out_acc) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_class0_count) &&
      $stable(out_class1_count) && $stable(out_class2_count) &&
      $stable(out_cell_color) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // No result without an item inside
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted item");

  // Never more than two items inside
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more items inside than stages");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output is free");

endmodule

bind class_count_summed_area_table csat_checker u_csat_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_class0_count (out_class0_count),
  .out_class1_count (out_class1_count),
  .out_class2_count (out_class2_count),
  .out_cell_color   (out_cell_color),
  .out_frame_end    (out_frame_end)
);
